FILE: src/hpms_pkg.sv
// ----------------------------------------------------------------------------
// hpms_pkg - heat pump mode selector shared definitions
// Request structs, lane and merge records, mode codes and sizing constants.
// ----------------------------------------------------------------------------
package hpms_pkg;

  localparam int NUM_THERMOSTATS = 4;
  localparam int NUM_FANCOILS    = 4;

  // Width of the thermostat and fancoil bit fields on the ports
  localparam int FIELD_W  = 4;
  localparam int TS_LANES = (NUM_THERMOSTATS < FIELD_W) ? NUM_THERMOSTATS : FIELD_W;
  localparam int FC_LANES = (NUM_FANCOILS < FIELD_W) ? NUM_FANCOILS : FIELD_W;

  localparam int TIMER_W = 16;
  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

  localparam logic [15:0] C2H_LOCKOUT_RST = 16'd300;
  localparam logic [15:0] H2C_LOCKOUT_RST = 16'd300;
  localparam logic [15:0] STBY_DELAY_RST  = 16'd60;

  typedef enum logic [1:0] {
    CFG_C2H_LOCKOUT = 2'd0,
    CFG_H2C_LOCKOUT = 2'd1,
    CFG_STBY_DELAY  = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_STANDBY = 2'd1,
    MODE_HEAT    = 2'd2,
    MODE_COOL    = 2'd3
  } mode_t;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  typedef struct packed {
    logic               kind;
    logic               system_on;
    logic [FIELD_W-1:0] thermostat_heat_bits;
    logic [FIELD_W-1:0] thermostat_cool_bits;
    logic [FIELD_W-1:0] fancoil_valid_bits;
    logic [FIELD_W-1:0] fancoil_heat_bits;
    logic               valve_switch_active;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         pump_mode;
    logic [FIELD_W-1:0] valve_targets;
    logic               zone_pump;
    logic               fancoil_pump;
    logic               demand_conflict;
    logic               lockout_hit;
    logic               wire_fault;
  } out_item_t;

  // One thermostat lane's decoded call
  typedef struct packed {
    logic heat;
    logic cool;
    logic fault;
  } ts_call_t;

  // One fancoil lane's decoded call
  typedef struct packed {
    logic heat;
    logic cool;
  } fc_call_t;

  // Merged demand picture handed to the mode logic
  typedef struct packed {
    logic [FIELD_W-1:0] ts_heat;
    logic [FIELD_W-1:0] ts_cool;
    logic               fc_heat_any;
    logic               fc_cool_any;
    logic               heat_wanted;
    logic               cool_wanted;
    logic               fault;
  } demand_t;

endpackage

FILE: src/heat_pump_mode_selector_unit.sv
// ----------------------------------------------------------------------------
// heat_pump_mode_selector_unit - heat pump mode selector
// Picks off, standby, heat or cool from thermostat and fancoil calls, with
// changeover lockout and standby delay, and drives valve targets and pumps.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------
//  in_     | input     | in_valid / in_stall     | in_item_t  (tick or eval)
//  out_    | output    | out_valid / out_stall   | out_item_t (one per eval)
//  cfg_    | input     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
//  One request is taken every cycle while in_stall is low; an evaluation's
//  result appears in the output register on the cycle after it is taken, a
//  tick gives no result. The decide path on the mode and timer registers is
//  combinational: one request per clock while in_stall is low.
//  Reset: mode off, both timers saturated, registers at 300 / 300 / 60.
//  in_stall rises only while a result sits in the output register and the
//  sink stalls; cfg_ready is always high.
// ----------------------------------------------------------------------------
module heat_pump_mode_selector_unit
  import hpms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers
  logic [15:0] c2h_lockout_r;
  logic [15:0] h2c_lockout_r;
  logic [15:0] stby_delay_r;

  // Mode state and changeover timers
  mode_t              prev_mode_r, prev_mode_nxt;
  logic [TIMER_W-1:0] since_heat_r, since_heat_nxt;
  logic [TIMER_W-1:0] since_cool_r, since_cool_nxt;

  // Output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic      in_accept;
  ts_call_t  ts_calls [TS_LANES];
  fc_call_t  fc_calls [FC_LANES];
  demand_t   demand;

  mode_t       mode_req;
  mode_t       mode_fin;
  logic        conflict;
  logic        lockout;
  logic [FIELD_W-1:0] targets;
  logic        fc_pump;

  // ---- Handshakes ----------------------------------------------------------
  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---- Lanes: one decoder per thermostat and per fancoil --------------------
  for (genvar gi = 0; gi < TS_LANES; gi++) begin : g_ts
    hpms_ts_lane u_lane (
      .w_wire (in_data.thermostat_heat_bits[gi]),
      .y_wire (in_data.thermostat_cool_bits[gi]),
      .call   (ts_calls[gi])
    );
  end

  for (genvar gj = 0; gj < FC_LANES; gj++) begin : g_fc
    hpms_fc_lane u_lane (
      .valid_wire (in_data.fancoil_valid_bits[gj]),
      .ob_wire    (in_data.fancoil_heat_bits[gj]),
      .call       (fc_calls[gj])
    );
  end

  hpms_merge u_merge (
    .ts_calls (ts_calls),
    .fc_calls (fc_calls),
    .demand   (demand)
  );

  // ---- Mode decision ------------------------------------------------------
  // A changeover is held while the other mode ran more recently than the
  // target mode and still within the lockout interval.
  always_comb begin
    conflict = 1'b0;
    lockout  = 1'b0;
    mode_req = MODE_STANDBY;
    if (demand.heat_wanted && demand.cool_wanted) begin
      // Conflicting demands: keep running heat or cool, else wait in standby
      conflict = 1'b1;
      if (prev_mode_r == MODE_HEAT || prev_mode_r == MODE_COOL) begin
        mode_req = prev_mode_r;
      end
    end else if (demand.heat_wanted) begin
      if ((since_cool_r < since_heat_r) && (since_cool_r < c2h_lockout_r)) begin
        lockout = 1'b1;
      end else begin
        mode_req = MODE_HEAT;
      end
    end else if (demand.cool_wanted) begin
      if ((since_heat_r < since_cool_r) && (since_heat_r < h2c_lockout_r)) begin
        lockout = 1'b1;
      end else begin
        mode_req = MODE_COOL;
      end
    end

    // Standby delay: keep an ended heat or cool call running for a while
    mode_fin = mode_req;
    if (mode_req == MODE_STANDBY &&
        ((prev_mode_r == MODE_HEAT && !demand.cool_wanted &&
          since_heat_r < stby_delay_r) ||
         (prev_mode_r == MODE_COOL && !demand.heat_wanted &&
          since_cool_r < stby_delay_r))) begin
      mode_fin = prev_mode_r;
    end

    // System off overrides everything but the wiring fault
    if (!in_data.system_on) begin
      mode_fin = MODE_OFF;
      conflict = 1'b0;
      lockout  = 1'b0;
    end
  end

  always_comb begin
    targets = '0;
    fc_pump = 1'b0;
    unique case (mode_fin)
      MODE_HEAT: begin
        targets = demand.ts_heat;
        fc_pump = demand.fc_heat_any;
      end
      MODE_COOL: begin
        targets = demand.ts_cool;
        fc_pump = demand.fc_cool_any;
      end
      default: begin
        targets = '0;
        fc_pump = 1'b0;
      end
    endcase
  end

  // ---- State and timer update -------------------------------------------
  always_comb begin
    prev_mode_nxt  = prev_mode_r;
    since_heat_nxt = since_heat_r;
    since_cool_nxt = since_cool_r;
    if (in_accept) begin
      if (in_data.kind == KIND_TICK) begin
        // Advance both timers, saturating
        if (since_heat_r != TIMER_MAX) since_heat_nxt = since_heat_r + 1'b1;
        if (since_cool_r != TIMER_MAX) since_cool_nxt = since_cool_r + 1'b1;
      end else if (in_data.system_on) begin
        // Restart the timer of the mode requested before the standby hold
        if (mode_req == MODE_HEAT) since_heat_nxt = '0;
        else if (mode_req == MODE_COOL) since_cool_nxt = '0;
        prev_mode_nxt = mode_fin;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_accept && in_data.kind == KIND_EVAL) begin
      out_valid_nxt                = 1'b1;
      out_data_nxt.pump_mode       = mode_fin;
      out_data_nxt.valve_targets   = targets;
      out_data_nxt.zone_pump       = (|targets) & in_data.valve_switch_active;
      out_data_nxt.fancoil_pump    = fc_pump;
      out_data_nxt.demand_conflict = conflict;
      out_data_nxt.lockout_hit     = lockout;
      out_data_nxt.wire_fault      = demand.fault;
    end else if (!out_stall) begin
      // Drop the result once the sink has taken it
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2h_lockout_r <= C2H_LOCKOUT_RST;
      h2c_lockout_r <= H2C_LOCKOUT_RST;
      stby_delay_r  <= STBY_DELAY_RST;
      prev_mode_r   <= MODE_OFF;
      since_heat_r  <= TIMER_MAX;
      since_cool_r  <= TIMER_MAX;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_C2H_LOCKOUT: c2h_lockout_r <= cfg_data;
          CFG_H2C_LOCKOUT: h2c_lockout_r <= cfg_data;
          CFG_STBY_DELAY:  stby_delay_r  <= cfg_data;
          default: begin
          end
        endcase
      end
      prev_mode_r  <= prev_mode_nxt;
      since_heat_r <= since_heat_nxt;
      since_cool_r <= since_cool_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_off_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.pump_mode == MODE_OFF) |->
      (out_data_r.valve_targets == '0 && !out_data_r.zone_pump &&
       !out_data_r.fancoil_pump && !out_data_r.lockout_hit))
    else $error("off result drives valves or pumps");

  a_zone_needs_target: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.zone_pump) |-> (out_data_r.valve_targets != '0))
    else $error("zone pump enabled without a valve target");

  a_lockout_standby: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.lockout_hit) |->
      (out_data_r.pump_mode == MODE_STANDBY || out_data_r.pump_mode == MODE_HEAT ||
       out_data_r.pump_mode == MODE_COOL))
    else $error("lockout reported with mode off");

  a_tick_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_data.kind == KIND_TICK && !out_valid_r) |=> !out_valid_r)
    else $error("tick produced a result");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled result changed");
`endif

endmodule

FILE: src/hpms_ts_lane.sv
// ----------------------------------------------------------------------------
// hpms_ts_lane - thermostat lane
// Decodes one thermostat's W and Y wires into a heat call, a cool call and
// a wiring fault.
// ----------------------------------------------------------------------------
module hpms_ts_lane
  import hpms_pkg::*;
(
  input  logic     w_wire,
  input  logic     y_wire,
  output ts_call_t call
);

  // Both wires set: flag the fault, call nothing
  always_comb begin
    call.heat  = w_wire & ~y_wire;
    call.cool  = y_wire & ~w_wire;
    call.fault = w_wire & y_wire;
  end

endmodule

FILE: src/hpms_fc_lane.sv
// ----------------------------------------------------------------------------
// hpms_fc_lane - fancoil lane
// Decodes one fancoil's call-present and OB wires into heat and cool calls.
// ----------------------------------------------------------------------------
module hpms_fc_lane
  import hpms_pkg::*;
(
  input  logic     valid_wire,
  input  logic     ob_wire,
  output fc_call_t call
);

  always_comb begin
    call.heat = valid_wire & ob_wire;
    call.cool = valid_wire & ~ob_wire;
  end

endmodule

FILE: src/hpms_merge.sv
// ----------------------------------------------------------------------------
// hpms_merge - lane merge
// Collects the lane calls into target vectors and overall heat, cool and
// fault flags.
// ----------------------------------------------------------------------------
module hpms_merge
  import hpms_pkg::*;
(
  input  ts_call_t ts_calls [TS_LANES],
  input  fc_call_t fc_calls [FC_LANES],
  output demand_t  demand
);

  always_comb begin
    demand = '0;
    for (int i = 0; i < TS_LANES; i++) begin
      demand.ts_heat[i] = ts_calls[i].heat;
      demand.ts_cool[i] = ts_calls[i].cool;
      demand.fault      = demand.fault | ts_calls[i].fault;
    end
    for (int j = 0; j < FC_LANES; j++) begin
      demand.fc_heat_any = demand.fc_heat_any | fc_calls[j].heat;
      demand.fc_cool_any = demand.fc_cool_any | fc_calls[j].cool;
    end
    demand.heat_wanted = (|demand.ts_heat) | demand.fc_heat_any;
    demand.cool_wanted = (|demand.ts_cool) | demand.fc_cool_any;
  end

endmodule

FILE: tb/tb_heat_pump_mode_selector_unit.sv
// ----------------------------------------------------------------------------
// tb_heat_pump_mode_selector_unit - heat pump mode selector testbench
// Drives tick and evaluation requests through the stall handshake. An
// in-bench predictor of the mode, timer and changeover logic scores every
// result field by field, over several register settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_heat_pump_mode_selector_unit;
  import hpms_pkg::*;

  localparam logic [FIELD_W-1:0] TS_MASK = FIELD_W'((1 << TS_LANES) - 1);
  localparam logic [FIELD_W-1:0] FC_MASK = FIELD_W'((1 << FC_LANES) - 1);

  // Shapes of random evaluation requests
  typedef enum logic [1:0] {
    SHAPE_HEAT,
    SHAPE_COOL,
    SHAPE_QUIET,
    SHAPE_NOISE
  } demand_shape_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_item_t   in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_idx_t   cfg_index = CFG_C2H_LOCKOUT;
  logic [15:0] cfg_data = '0;

  heat_pump_mode_selector_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of the block's registers and state
  logic [15:0] c2h_lockout;
  logic [15:0] h2c_lockout;
  logic [15:0] stby_delay;
  mode_t       last_mode;
  logic [TIMER_W-1:0] since_heat;
  logic [TIMER_W-1:0] since_cool;

  in_item_t    pending_requests_q[$];  // requests waiting for the driver
  out_item_t   mode_results_q[$];      // predicted results, oldest first
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  logic        req_taken      = 1'b0;  // request accepted at the last rising edge
  logic        drain_hold     = 1'b0;  // sender waits for every result to arrive

  initial forever #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // A changeover is held back only while the other mode ran more recently
  // than the requested one and still lies inside the lockout interval;
  // equal timers never hold.
  function automatic logic changeover_held(logic [TIMER_W-1:0] since_target,
                                           logic [TIMER_W-1:0] since_other,
                                           logic [15:0] interval);
    return (since_other < since_target) && (since_other < interval);
  endfunction

  task automatic predict_mode_selection(input in_item_t r);
    logic [FIELD_W-1:0] w, y, fc_valid, fc_ob;
    logic [FIELD_W-1:0] ts_heat, ts_cool, fc_heat, fc_cool;
    logic               heat_call, cool_call;
    mode_t              mode;
    out_item_t          res;
    if (r.kind == KIND_TICK) begin
      // Ticks advance both timers, saturating, and give no result
      if (since_heat != TIMER_MAX) since_heat = since_heat + 1'b1;
      if (since_cool != TIMER_MAX) since_cool = since_cool + 1'b1;
    end else begin
      w        = r.thermostat_heat_bits & TS_MASK;
      y        = r.thermostat_cool_bits & TS_MASK;
      fc_valid = r.fancoil_valid_bits & FC_MASK;
      fc_ob    = r.fancoil_heat_bits & FC_MASK;
      res      = '0;
      // A thermostat with W and Y both set calls nothing but is flagged
      res.wire_fault = |(w & y);
      ts_heat   = w & ~y;
      ts_cool   = y & ~w;
      fc_heat   = fc_valid & fc_ob;
      fc_cool   = fc_valid & ~fc_ob;
      heat_call = |{ts_heat, fc_heat};
      cool_call = |{ts_cool, fc_cool};

      if (!r.system_on) begin
        // System off: mode off, state left alone
        mode = MODE_OFF;
      end else begin
        if (heat_call && cool_call) begin
          res.demand_conflict = 1'b1;
          mode = (last_mode == MODE_HEAT || last_mode == MODE_COOL) ? last_mode : MODE_STANDBY;
        end else if (heat_call) begin
          if (changeover_held(since_heat, since_cool, c2h_lockout)) begin
            res.lockout_hit = 1'b1;
            mode = MODE_STANDBY;
          end else begin
            mode = MODE_HEAT;
          end
        end else if (cool_call) begin
          if (changeover_held(since_cool, since_heat, h2c_lockout)) begin
            res.lockout_hit = 1'b1;
            mode = MODE_STANDBY;
          end else begin
            mode = MODE_COOL;
          end
        end else begin
          mode = MODE_STANDBY;
        end

        if (mode == MODE_HEAT) since_heat = '0;
        else if (mode == MODE_COOL) since_cool = '0;

        // Keep heat or cool for the standby delay after the call ends
        if (mode == MODE_STANDBY &&
            ((last_mode == MODE_HEAT && !cool_call && since_heat < stby_delay) ||
             (last_mode == MODE_COOL && !heat_call && since_cool < stby_delay)))
          mode = last_mode;
        last_mode = mode;
      end

      res.pump_mode = mode;
      if (mode == MODE_HEAT) begin
        res.valve_targets = ts_heat;
        res.fancoil_pump  = |fc_heat;
      end else if (mode == MODE_COOL) begin
        res.valve_targets = ts_cool;
        res.fancoil_pump  = |fc_cool;
      end
      res.zone_pump = (|res.valve_targets) && r.valve_switch_active;
      mode_results_q.push_back(res);
    end
  endtask

  // --------------------------------------------------------------------------
  // Scoring
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic score_result(input out_item_t got);
    out_item_t want;
    if (mode_results_q.size() == 0) begin
      $display("%0t: result expected none actual %h", $time, got);
      mismatch_count++;
    end else begin
      want = mode_results_q.pop_front();
      check_field("pump_mode",       want.pump_mode,       got.pump_mode);
      check_field("valve_targets",   want.valve_targets,   got.valve_targets);
      check_field("zone_pump",       want.zone_pump,       got.zone_pump);
      check_field("fancoil_pump",    want.fancoil_pump,    got.fancoil_pump);
      check_field("demand_conflict", want.demand_conflict, got.demand_conflict);
      check_field("lockout_hit",     want.lockout_hit,     got.lockout_hit);
      check_field("wire_fault",      want.wire_fault,      got.wire_fault);
    end
  endtask

  // Monitor: score results first, since a result never leaves on the edge
  // that takes its request, then predict from the request taken at this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) score_result(out_data);
      req_taken = in_valid && !in_stall;
      if (req_taken) predict_mode_selection(in_data);
    end else begin
      req_taken = 1'b0;
    end
  end

  // Driver: hold a stalled request; otherwise idle at random, or present
  // the next pending one. Now and then wait for every result before going on.
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !req_taken)) begin
      if (drain_hold && mode_results_q.size() == 0) drain_hold = 1'b0;
      if (!drain_hold && pending_requests_q.size() != 0 && $urandom_range(0, 299) == 0)
        drain_hold = 1'b1;
      if (drain_hold || pending_requests_q.size() == 0 ||
          $urandom_range(0, 99) < send_idle_pct) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data  <= pending_requests_q.pop_front();
      end
    end
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Request builders
  // --------------------------------------------------------------------------
  function automatic in_item_t eval_req(logic on, logic [FIELD_W-1:0] w,
                                        logic [FIELD_W-1:0] y, logic [FIELD_W-1:0] fv,
                                        logic [FIELD_W-1:0] fob, logic vsa);
    in_item_t r;
    r.kind                 = KIND_EVAL;
    r.system_on            = on;
    r.thermostat_heat_bits = w;
    r.thermostat_cool_bits = y;
    r.fancoil_valid_bits   = fv;
    r.fancoil_heat_bits    = fob;
    r.valve_switch_active  = vsa;
    return r;
  endfunction

  // Tick with random don't-care fields
  function automatic in_item_t random_tick();
    in_item_t r;
    r = eval_req(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    r.kind = KIND_TICK;
    return r;
  endfunction

  // Mostly clean heat or cool calls, some quiet and some pure noise
  function automatic in_item_t random_eval();
    demand_shape_t      shape;
    logic [FIELD_W-1:0] w, y, fv, fob;
    int unsigned        pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) shape = SHAPE_HEAT;
    else if (pick < 6) shape = SHAPE_COOL;
    else if (pick < 8) shape = SHAPE_QUIET;
    else shape = SHAPE_NOISE;
    w   = 4'($urandom_range(0, 15));
    y   = 4'($urandom_range(0, 15));
    fv  = 4'($urandom_range(0, 15));
    fob = 4'($urandom_range(0, 15));
    case (shape)
      SHAPE_HEAT: begin
        y   = ($urandom_range(0, 3) == 0) ? (y & w) : '0;
        fob = fob | fv;
      end
      SHAPE_COOL: begin
        w   = ($urandom_range(0, 3) == 0) ? (w & y) : '0;
        fob = fob & ~fv;
      end
      SHAPE_QUIET: begin
        // Faulted thermostats only, no fancoil calls
        y  = ($urandom_range(0, 1) == 0) ? w : '0;
        w  = y;
        fv = '0;
      end
      default: ;
    endcase
    return eval_req($urandom_range(0, 11) != 0, w, y, fv, fob, $urandom_range(0, 3) != 0);
  endfunction

  task automatic queue_traffic(input int unsigned count);
    int unsigned n;
    int unsigned burst;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 2) == 0) begin
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 5);
        repeat (burst) pending_requests_q.push_back(random_tick());
        n += burst;
      end else begin
        pending_requests_q.push_back(random_eval());
        n++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Register access and phase control
  // --------------------------------------------------------------------------
  task automatic write_register(input cfg_idx_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_C2H_LOCKOUT: c2h_lockout = value;
      CFG_H2C_LOCKOUT: h2c_lockout = value;
      CFG_STBY_DELAY:  stby_delay  = value;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [15:0] c2h, input logic [15:0] h2c,
                           input logic [15:0] delay);
    write_register(CFG_C2H_LOCKOUT, c2h);
    write_register(CFG_H2C_LOCKOUT, h2c);
    write_register(CFG_STBY_DELAY, delay);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every request has gone in and every result has come out,
  // then let a trailing tick settle before touching the registers.
  task automatic wait_until_quiet();
    while (pending_requests_q.size() != 0 || in_valid || mode_results_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned phase;
    c2h_lockout = C2H_LOCKOUT_RST;
    h2c_lockout = H2C_LOCKOUT_RST;
    stby_delay  = STBY_DELAY_RST;
    last_mode   = MODE_OFF;
    since_heat  = TIMER_MAX;
    since_cool  = TIMER_MAX;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 12;
    recv_idle_pct = 47;

    // Directed part at the reset register values
    pending_requests_q.push_back(eval_req(1'b0, 4'hF, 4'hF, 4'hF, 4'hF, 1'b1)); // off, faulted
    pending_requests_q.push_back(eval_req(1'b1, 4'h0, 4'h0, 4'h0, 4'h0, 1'b0)); // no call
    pending_requests_q.push_back(eval_req(1'b1, 4'hF, 4'h0, 4'hF, 4'hF, 1'b1)); // heat, equal timers
    pending_requests_q.push_back(eval_req(1'b1, 4'h0, 4'hF, 4'hF, 4'h0, 1'b1)); // cool locked out
    pending_requests_q.push_back(random_tick());
    pending_requests_q.push_back(eval_req(1'b1, 4'h0, 4'h0, 4'h0, 4'h0, 1'b1)); // standby
    pending_requests_q.push_back(eval_req(1'b1, 4'h1, 4'h2, 4'h0, 4'h0, 1'b1)); // conflict
    pending_requests_q.push_back(eval_req(1'b1, 4'h1, 4'h0, 4'h0, 4'h0, 1'b1)); // heat again
    pending_requests_q.push_back(eval_req(1'b1, 4'h1, 4'h2, 4'h0, 4'h0, 1'b1)); // conflict keeps heat
    pending_requests_q.push_back(eval_req(1'b1, 4'h0, 4'h0, 4'h0, 4'h0, 1'b1)); // standby delay
    pending_requests_q.push_back(eval_req(1'b1, 4'h0, 4'h0, 4'h5, 4'h0, 1'b1)); // fancoil cool
    pending_requests_q.push_back(eval_req(1'b1, 4'hA, 4'hA, 4'h0, 4'hF, 1'b1)); // fault only
    pending_requests_q.push_back(eval_req(1'b0, 4'hF, 4'h0, 4'hF, 4'hF, 1'b1)); // off with call
    pending_requests_q.push_back(eval_req(1'b1, 4'h8, 4'h0, 4'h0, 4'h0, 1'b0)); // valve switch idle
    pending_requests_q.push_back(eval_req(1'b1, 4'h0, 4'h0, 4'h3, 4'h1, 1'b1)); // fancoil conflict
    pending_requests_q.push_back(eval_req(1'b1, 4'h0, 4'h0, 4'h0, 4'hF, 1'b1)); // OB without valid
    wait_until_quiet();

    for (phase = 0; phase < 6; phase++) begin
      if (phase >= 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (phase >= 2) begin
        send_idle_pct = 47;
        recv_idle_pct = 12;
      end
      case (phase)
        0: configure(16'd0, 16'd0, 16'd0);
        1: configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: begin
          write_register(CFG_UNUSED, 16'($urandom_range(0, 65535)));
          configure(16'($urandom_range(1, 10)), 16'($urandom_range(1, 10)),
                    16'($urandom_range(1, 10)));
        end
        3: configure(16'($urandom_range(0, 30)), 16'($urandom_range(0, 30)),
                     16'($urandom_range(0, 12)));
        4: configure(16'($urandom_range(0, 65535)), 16'($urandom_range(1, 8)),
                     16'($urandom_range(0, 65535)));
        default: configure(16'($urandom_range(1, 20)), 16'($urandom_range(1, 20)),
                           16'($urandom_range(1, 20)));
      endcase
      queue_traffic(135);
      wait_until_quiet();
    end

    if (mismatch_count == 0 && mode_results_q.size() == 0)
      $display("heat_pump_mode_selector_unit: match");
    else
      $display("heat_pump_mode_selector_unit: mismatch");
    $finish;
  end

  // Watchdog
  initial begin
    #20000000;
    $display("heat_pump_mode_selector_unit: mismatch");
    $finish;
  end

endmodule
